// File: hdl/preferential_attachment_graph_assert.svh
// assertion macros shared by the checker
`ifndef PREFERENTIAL_ATTACHMENT_GRAPH_ASSERT_SVH
`define PREFERENTIAL_ATTACHMENT_GRAPH_ASSERT_SVH

// clocked property, off while reset is high
`define PAG_ASSERT(lbl, clk_s, rst_s, prop) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) prop) \
    else $error("pag assertion failed");

// clocked property, checked during reset too
`define PAG_ASSERT_NR(lbl, clk_s, prop) \
  lbl: assert property (@(posedge clk_s) prop) \
    else $error("pag assertion failed");

`endif

// File: hdl/pag_pkg.sv
package pag_pkg;

  localparam int NODES    = 4096;
  localparam int NODE_AW  = 12;
  localparam int EDGES    = 16384;
  localparam int EDGE_AW  = 14;
  localparam int LINKS    = 64;
  localparam int LINK_AW  = 6;
  localparam int DEG_W    = 15;

  localparam logic [6:0] LINKS_MAX = 7'd64;
  localparam logic [15:0] SEED_PROD_MAX = 16'(2 * EDGES);

  typedef enum logic [2:0] {
    OP_SEED   = 3'd0,
    OP_STEP   = 3'd1,
    OP_ATTACH = 3'd2,
    OP_DELETE = 3'd3,
    OP_READ   = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_REJECT = 3'd1,
    ST_DEAD   = 3'd2,
    ST_EMPTY  = 3'd3,
    ST_FULL   = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    CFG_SEED_NODES     = 2'd0,
    CFG_LINKS_PER_NODE = 2'd1,
    CFG_GROW_THRESHOLD = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [NODE_AW-1:0] a;
    logic [NODE_AW-1:0] b;
    logic               alive;
  } edge_t;

endpackage

// File: hdl/pag_in_if.sv
interface pag_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  op;
  logic [15:0] rand_value;
  logic [13:0] edge_slot;

  modport source (output valid, op, rand_value, edge_slot, input ready);
  modport sink (input valid, op, rand_value, edge_slot, output ready);
endinterface

// File: hdl/pag_out_if.sv
interface pag_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic        chose_grow;
  logic [11:0] node_id;
  logic        node_complete;
  logic [11:0] edge_end_a;
  logic [11:0] edge_end_b;
  logic        edge_alive;
  logic [12:0] live_nodes;
  logic [15:0] degree_total;

  modport source (output valid, status, chose_grow, node_id, node_complete, edge_end_a,
                  edge_end_b, edge_alive, live_nodes, degree_total, input ready);
  modport sink (input valid, status, chose_grow, node_id, node_complete, edge_end_a,
                edge_end_b, edge_alive, live_nodes, degree_total, output ready);
endinterface

// File: hdl/pag_cfg_if.sv
interface pag_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [16:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: hdl/preferential_attachment_graph.sv
// channel    dir  beat carries
// item_in    in   op, rand_value, edge_slot
// result_out out  status, chose_grow, node_id, node_complete, edge ends, counts
// cfg        in   index, data (seed_nodes, links_per_node, grow_threshold)
//
// one item at a time; ops 1 and 5-7 answer directly, op 4 after an edge read when the slot is in range
// attach: a degree walk up to the target, then a scan of the links already made
// delete: a remainder division when steps were taken, then an edge list scan with a degree update per hit
// seed: a sweep of all 4096 degree entries, then one edge write per seed edge
// after reset a sweep of all 4096 entries clears the degree memory; no item is taken meanwhile
// a result waits in the output register while the next beat is taken
module preferential_attachment_graph
  import pag_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  pag_in_if.sink   item_in,
  pag_out_if.source result_out,
  pag_cfg_if.sink  cfg
);

  typedef enum logic [18:0] {
    S_CLEAR     = 19'b1 << 0,
    S_IDLE      = 19'b1 << 1,
    S_SEED_EDGE = 19'b1 << 2,
    S_AT_MUL    = 19'b1 << 3,
    S_AT_WALK   = 19'b1 << 4,
    S_AT_NCHK   = 19'b1 << 5,
    S_AT_SCAN   = 19'b1 << 6,
    S_AT_PRD    = 19'b1 << 7,
    S_AT_PDEG   = 19'b1 << 8,
    S_AT_WB     = 19'b1 << 9,
    S_DIV       = 19'b1 << 10,
    S_DEL_CAND  = 19'b1 << 11,
    S_DEL_CCHK  = 19'b1 << 12,
    S_DEL_ERD   = 19'b1 << 13,
    S_DEL_ECHK  = 19'b1 << 14,
    S_DEL_DWB   = 19'b1 << 15,
    S_DEL_FIN   = 19'b1 << 16,
    S_RD_EDGE   = 19'b1 << 17,
    S_RESP      = 19'b1 << 18
  } state_t;

  state_t state;

  // config
  logic [6:0]  seed_nodes;
  logic [6:0]  links_per_node;
  logic [16:0] grow_threshold;

  // scalar state
  logic [14:0] edge_count;
  logic [15:0] degree_sum;
  logic [12:0] new_node;
  logic [31:0] step_count;
  logic [12:0] alive_count;

  // memories
  logic [DEG_W-1:0]   deg_mem [NODES];
  edge_t              edge_mem [EDGES];
  logic [NODE_AW-1:0] lt_mem [LINKS];

  logic               deg_we;
  logic [NODE_AW-1:0] deg_waddr;
  logic [DEG_W-1:0]   deg_wdata;
  logic [NODE_AW-1:0] deg_raddr;
  logic [DEG_W-1:0]   deg_rdata;

  logic               edge_we;
  logic [EDGE_AW-1:0] edge_waddr;
  edge_t              edge_wdata;
  logic [EDGE_AW-1:0] edge_raddr;
  edge_t              edge_rdata;

  logic               lt_we;
  logic [LINK_AW-1:0] lt_raddr;
  logic [NODE_AW-1:0] lt_rdata;

  // working registers
  logic [15:0]        rand_r;
  logic [NODE_AW-1:0] clear_addr;
  logic [6:0]         fill_n;
  logic               seeding;
  logic [6:0]         seed_i;
  logic [6:0]         seed_j;
  logic [31:0]        goal;
  logic [16:0]        cum;
  logic [NODE_AW-1:0] walk_tag;
  logic [NODE_AW-1:0] target;
  logic [DEG_W-1:0]   d_reg;
  logic [LINK_AW-1:0] scan_j;
  logic [3:0]         div_bit;
  logic [15:0]        rem;
  logic [15:0]        cand;
  logic [14:0]        q;
  logic [NODE_AW-1:0] other_r;

  // result under construction
  logic [2:0]         res_status;
  logic               res_grow;
  logic [11:0]        res_node;
  logic               res_done;
  logic [11:0]        res_ea;
  logic [11:0]        res_eb;
  logic               res_ev;

  // output register
  logic        out_valid;
  logic [2:0]  out_status;
  logic        out_grow;
  logic [11:0] out_node;
  logic        out_done;
  logic [11:0] out_ea;
  logic [11:0] out_eb;
  logic        out_ev;
  logic [12:0] out_live;
  logic [15:0] out_total;

  // derived values
  logic [6:0]  m0;
  logic [13:0] m0_prod;
  logic [6:0]  m_eff;
  logic [16:0] cum_new;
  logic        walk_hit;
  logic [16:0] div_t;
  logic        div_ge;
  logic        edge_hit;
  logic [NODE_AW-1:0] edge_other;
  logic        in_acc;

  assign in_acc  = item_in.valid && item_in.ready;
  assign m0      = (seed_nodes < 7'd2) ? 7'd2 : seed_nodes;
  assign m0_prod = 14'(m0) * 14'(m0 - 7'd1);
  assign m_eff   = (links_per_node == 7'd0) ? 7'd1 :
                   ((links_per_node > LINKS_MAX) ? LINKS_MAX : links_per_node);

  assign cum_new  = cum + 17'(deg_rdata);
  assign walk_hit = ({cum_new, 16'b0} >= {1'b0, goal}) || (&walk_tag);

  assign div_t  = {rem, rand_r[div_bit]};
  assign div_ge = {15'b0, div_t} >= step_count;

  assign edge_hit   = edge_rdata.alive &&
                      (edge_rdata.a == cand[NODE_AW-1:0] || edge_rdata.b == cand[NODE_AW-1:0]);
  assign edge_other = (edge_rdata.a == cand[NODE_AW-1:0]) ? edge_rdata.b : edge_rdata.a;

  assign item_in.ready = (state == S_IDLE);
  assign cfg.ready     = 1'b1;

  assign result_out.valid         = out_valid;
  assign result_out.status        = out_status;
  assign result_out.chose_grow    = out_grow;
  assign result_out.node_id       = out_node;
  assign result_out.node_complete = out_done;
  assign result_out.edge_end_a    = out_ea;
  assign result_out.edge_end_b    = out_eb;
  assign result_out.edge_alive    = out_ev;
  assign result_out.live_nodes    = out_live;
  assign result_out.degree_total  = out_total;

  // memory port control
  always_comb begin
    deg_we     = 1'b0;
    deg_waddr  = '0;
    deg_wdata  = '0;
    deg_raddr  = '0;
    edge_we    = 1'b0;
    edge_waddr = edge_count[EDGE_AW-1:0];
    edge_wdata = '0;
    edge_raddr = item_in.edge_slot;
    lt_we      = 1'b0;
    lt_raddr   = '0;
    case (state)
      S_CLEAR: begin
        deg_we    = 1'b1;
        deg_waddr = clear_addr;
        deg_wdata = (clear_addr < NODE_AW'(fill_n)) ? DEG_W'(fill_n - 7'd1) : '0;
      end
      S_SEED_EDGE: begin
        edge_we    = 1'b1;
        edge_wdata = '{a: NODE_AW'(seed_i), b: NODE_AW'(seed_j), alive: 1'b1};
      end
      S_AT_WALK: begin
        deg_raddr = walk_hit ? new_node[NODE_AW-1:0] : walk_tag + 1'b1;
      end
      S_AT_SCAN: begin
        lt_raddr = scan_j + 1'b1;
      end
      S_AT_PRD: begin
        deg_raddr = target;
      end
      S_AT_PDEG: begin
        deg_we     = 1'b1;
        deg_waddr  = target;
        deg_wdata  = deg_rdata + 1'b1;
        edge_we    = 1'b1;
        edge_wdata = '{a: new_node[NODE_AW-1:0], b: target, alive: 1'b1};
        lt_we      = 1'b1;
      end
      S_AT_WB: begin
        deg_we    = 1'b1;
        deg_waddr = new_node[NODE_AW-1:0];
        deg_wdata = d_reg + 1'b1;
      end
      S_DEL_CAND: begin
        deg_raddr = cand[NODE_AW-1:0];
      end
      S_DEL_ERD: begin
        edge_raddr = q[EDGE_AW-1:0];
      end
      S_DEL_ECHK: begin
        deg_raddr = edge_other;
        if (edge_hit) begin
          edge_we    = 1'b1;
          edge_waddr = q[EDGE_AW-1:0];
          edge_wdata = '{a: edge_rdata.a, b: edge_rdata.b, alive: 1'b0};
        end
      end
      S_DEL_DWB: begin
        deg_we    = (deg_rdata != '0);
        deg_waddr = other_r;
        deg_wdata = deg_rdata - 1'b1;
      end
      S_DEL_FIN: begin
        deg_we    = 1'b1;
        deg_waddr = cand[NODE_AW-1:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (deg_we) begin
      deg_mem[deg_waddr] <= deg_wdata;
    end
    deg_rdata <= deg_mem[deg_raddr];
  end

  always_ff @(posedge clk) begin
    if (edge_we) begin
      edge_mem[edge_waddr] <= edge_wdata;
    end
    edge_rdata <= edge_mem[edge_raddr];
  end

  always_ff @(posedge clk) begin
    if (lt_we) begin
      lt_mem[d_reg[LINK_AW-1:0]] <= target;
    end
    lt_rdata <= lt_mem[lt_raddr];
  end

  // config port
  always_ff @(posedge clk) begin
    if (rst) begin
      seed_nodes     <= 7'd5;
      links_per_node <= 7'd4;
      grow_threshold <= '0;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        CFG_SEED_NODES:     seed_nodes     <= cfg.data[6:0];
        CFG_LINKS_PER_NODE: links_per_node <= cfg.data[6:0];
        CFG_GROW_THRESHOLD: grow_threshold <= cfg.data;
        default: begin
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_RESP && (!out_valid || result_out.ready)) begin
      out_valid <= 1'b1;
    end else if (result_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_RESP && (!out_valid || result_out.ready)) begin
      out_status <= res_status;
      out_grow   <= res_grow;
      out_node   <= res_node;
      out_done   <= res_done;
      out_ea     <= res_ea;
      out_eb     <= res_eb;
      out_ev     <= res_ev;
      out_live   <= alive_count;
      out_total  <= degree_sum;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      clear_addr  <= '0;
      fill_n      <= '0;
      seeding     <= 1'b0;
      edge_count  <= '0;
      degree_sum  <= '0;
      new_node    <= '0;
      step_count  <= '0;
      alive_count <= '0;
    end else begin
      case (state)
        S_CLEAR: begin
          clear_addr <= clear_addr + 1'b1;
          if (&clear_addr) begin
            state <= seeding ? S_SEED_EDGE : S_IDLE;
          end
        end

        S_IDLE: begin
          if (in_acc) begin
            rand_r     <= item_in.rand_value;
            res_status <= ST_OK;
            res_grow   <= 1'b0;
            res_node   <= '0;
            res_done   <= 1'b0;
            res_ea     <= '0;
            res_eb     <= '0;
            res_ev     <= 1'b0;
            state      <= S_RESP;
            case (item_in.op)
              OP_SEED: begin
                if ({2'b0, m0_prod} > SEED_PROD_MAX) begin
                  res_status <= ST_FULL;
                end else begin
                  fill_n      <= m0;
                  seeding     <= 1'b1;
                  clear_addr  <= '0;
                  edge_count  <= '0;
                  step_count  <= '0;
                  degree_sum  <= 16'(m0_prod);
                  alive_count <= 13'(m0);
                  new_node    <= 13'(m0);
                  seed_i      <= 7'd1;
                  seed_j      <= 7'd0;
                  state       <= S_CLEAR;
                end
              end
              OP_STEP: begin
                if (alive_count == '0) begin
                  res_status <= ST_EMPTY;
                end else begin
                  step_count <= step_count + 1'b1;
                  if ({1'b0, item_in.rand_value} >= grow_threshold) begin
                    res_grow <= 1'b1;
                    res_node <= new_node[11:0];
                    if (new_node[12]) begin
                      res_status <= ST_FULL;
                    end
                  end
                end
              end
              OP_ATTACH: begin
                state <= S_AT_MUL;
              end
              OP_DELETE: begin
                rem     <= '0;
                div_bit <= 4'd15;
                if (step_count == '0) begin
                  cand  <= item_in.rand_value;
                  state <= S_DEL_CAND;
                end else begin
                  state <= S_DIV;
                end
              end
              OP_READ: begin
                if ({1'b0, item_in.edge_slot} < edge_count) begin
                  state <= S_RD_EDGE;
                end
              end
              default: begin
              end
            endcase
          end
        end

        S_SEED_EDGE: begin
          edge_count <= edge_count + 1'b1;
          if (seed_j + 7'd1 == seed_i) begin
            seed_i <= seed_i + 7'd1;
            seed_j <= '0;
            if (seed_i + 7'd1 == fill_n) begin
              seeding <= 1'b0;
              state   <= S_RESP;
            end
          end else begin
            seed_j <= seed_j + 7'd1;
          end
        end

        // degree 0 read is issued here; unless the graph is full or empty, the walk starts next cycle
        S_AT_MUL: begin
          goal     <= degree_sum * rand_r;
          cum      <= '0;
          walk_tag <= '0;
          if (new_node[12]) begin
            res_status <= ST_FULL;
            state      <= S_RESP;
          end else if (degree_sum == '0) begin
            res_status <= ST_EMPTY;
            state      <= S_RESP;
          end else begin
            state <= S_AT_WALK;
          end
        end

        S_AT_WALK: begin
          cum <= cum_new;
          if (walk_hit) begin
            target   <= walk_tag;
            res_node <= walk_tag;
            state    <= S_AT_NCHK;
          end else begin
            walk_tag <= walk_tag + 1'b1;
          end
        end

        S_AT_NCHK: begin
          d_reg  <= deg_rdata;
          scan_j <= '0;
          if (target == new_node[NODE_AW-1:0]) begin
            res_status <= ST_REJECT;
            state      <= S_RESP;
          end else if (deg_rdata >= DEG_W'(LINKS)) begin
            res_status <= ST_FULL;
            state      <= S_RESP;
          end else if (deg_rdata == '0) begin
            state <= S_AT_PRD;
          end else begin
            state <= S_AT_SCAN;
          end
        end

        S_AT_SCAN: begin
          if (lt_rdata == target) begin
            res_status <= ST_REJECT;
            state      <= S_RESP;
          end else if ({1'b0, scan_j} + 7'd1 == d_reg[6:0]) begin
            state <= S_AT_PRD;
          end else begin
            scan_j <= scan_j + 1'b1;
          end
        end

        S_AT_PRD: begin
          if (edge_count[14]) begin
            res_status <= ST_FULL;
            state      <= S_RESP;
          end else begin
            state <= S_AT_PDEG;
          end
        end

        S_AT_PDEG: begin
          if (deg_rdata == '0) begin
            alive_count <= alive_count + 1'b1;
          end
          state <= S_AT_WB;
        end

        S_AT_WB: begin
          if (d_reg == '0) begin
            alive_count <= alive_count + 1'b1;
          end
          degree_sum <= degree_sum + 16'd2;
          edge_count <= edge_count + 1'b1;
          if (d_reg + 1'b1 >= DEG_W'(m_eff)) begin
            res_done <= 1'b1;
            new_node <= new_node + 1'b1;
          end
          state <= S_RESP;
        end

        // restoring remainder, one dividend bit per cycle
        S_DIV: begin
          rem     <= div_ge ? 16'(div_t - step_count[16:0]) : div_t[15:0];
          div_bit <= div_bit - 1'b1;
          if (div_bit == '0) begin
            cand  <= div_ge ? 16'(div_t - step_count[16:0]) : div_t[15:0];
            state <= S_DEL_CAND;
          end
        end

        S_DEL_CAND: begin
          res_node <= cand[11:0];
          if (cand[15:NODE_AW] != '0) begin
            res_status <= ST_DEAD;
            state      <= S_RESP;
          end else begin
            state <= S_DEL_CCHK;
          end
        end

        S_DEL_CCHK: begin
          q <= '0;
          if (deg_rdata == '0) begin
            res_status <= ST_DEAD;
            state      <= S_RESP;
          end else begin
            state <= S_DEL_ERD;
          end
        end

        S_DEL_ERD: begin
          state <= (q >= edge_count) ? S_DEL_FIN : S_DEL_ECHK;
        end

        S_DEL_ECHK: begin
          other_r <= edge_other;
          if (edge_hit) begin
            state <= S_DEL_DWB;
          end else begin
            q     <= q + 1'b1;
            state <= S_DEL_ERD;
          end
        end

        S_DEL_DWB: begin
          if (deg_rdata == DEG_W'(1) && alive_count != '0) begin
            alive_count <= alive_count - 1'b1;
          end
          degree_sum <= (degree_sum >= 16'd2) ? degree_sum - 16'd2 : '0;
          q          <= q + 1'b1;
          state      <= S_DEL_ERD;
        end

        S_DEL_FIN: begin
          if (alive_count != '0) begin
            alive_count <= alive_count - 1'b1;
          end
          state <= S_RESP;
        end

        S_RD_EDGE: begin
          res_ea <= edge_rdata.a;
          res_eb <= edge_rdata.b;
          res_ev <= edge_rdata.alive;
          state  <= S_RESP;
        end

        S_RESP: begin
          if (!out_valid || result_out.ready) begin
            state <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: hdl/pag_checker.sv
`include "preferential_attachment_graph_assert.svh"

module pag_checker
  import pag_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_status,
  input logic        out_grow,
  input logic [11:0] out_node,
  input logic        out_done,
  input logic        out_alive
);

  // a stalled result beat keeps its status and node id
  `PAG_ASSERT(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_node))

  // one item in flight at a time
  `PAG_ASSERT(a_single_item, clk, rst, in_valid && in_ready |=> !in_ready)

  // a completed node only comes with a successful attach
  `PAG_ASSERT(a_done_ok, clk, rst, out_valid && out_done |-> out_status == ST_OK && !out_grow && !out_alive)

  // reset starts the degree sweep with nothing to show
  `PAG_ASSERT_NR(a_reset_quiet, clk, $past(rst) && !rst |-> !out_valid && !in_ready)

endmodule

bind preferential_attachment_graph pag_checker u_pag_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (item_in.valid),
  .in_ready   (item_in.ready),
  .out_valid  (result_out.valid),
  .out_ready  (result_out.ready),
  .out_status (result_out.status),
  .out_grow   (result_out.chose_grow),
  .out_node   (result_out.node_id),
  .out_done   (result_out.node_complete),
  .out_alive  (result_out.edge_alive)
);

// File: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import pag_pkg::*;

  localparam int WATCHDOG_CYCLES = 80000;
  localparam int HOLD_CYCLES     = 400;

  typedef struct {
    logic [2:0]  op;
    logic [15:0] rand_value;
    logic [13:0] edge_slot;
  } graph_item_t;

  typedef struct {
    logic [2:0]  status;
    logic        chose_grow;
    logic [11:0] node_id;
    logic        node_complete;
    logic [11:0] edge_end_a;
    logic [11:0] edge_end_b;
    logic        edge_alive;
    logic [12:0] live_nodes;
    logic [15:0] degree_total;
  } graph_result_t;

  logic clk;
  logic rst;

  pag_in_if  item_if ();
  pag_out_if result_if ();
  pag_cfg_if cfg_if ();

  preferential_attachment_graph i_dut (
    .clk        (clk),
    .rst        (rst),
    .item_in    (item_if),
    .result_out (result_if),
    .cfg        (cfg_if)
  );

  graph_item_t   pending_items[$];
  graph_result_t expected_results[$];
  int            mismatches;
  int            idle_pct;
  int            stall_pct;
  int            hold_req;
  int            hold_seen;
  int            hold_left;
  int            quiet_cycles;

  // model copy of the graph
  int unsigned deg[NODES];
  logic [11:0] end_a[EDGES];
  logic [11:0] end_b[EDGES];
  bit          end_live[EDGES];
  int unsigned linked[LINKS];
  int unsigned n_edges, deg_sum, grow_node, steps, live_cnt;
  int unsigned seed_cfg, links_cfg, thresh_cfg;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic void drop_degree(int unsigned n);
    if (n < NODES && deg[n] > 0) begin
      deg[n]--;
      if (deg[n] == 0 && live_cnt > 0) live_cnt--;
    end
  endfunction

  function automatic void add_degree(int unsigned n);
    if (deg[n] == 0) live_cnt++;
    deg[n]++;
  endfunction

  function automatic void seed_graph(ref graph_result_t res);
    int unsigned m0;
    m0 = seed_cfg;
    if (m0 < 2) m0 = 2;
    if (m0 > NODES) m0 = NODES;
    if (longint'(m0) * (m0 - 1) / 2 > EDGES) begin
      res.status = ST_FULL;
      return;
    end
    foreach (deg[i]) deg[i] = 0;
    n_edges = 0;
    steps = 0;
    for (int unsigned i = 0; i < m0; i++) begin
      deg[i] = m0 - 1;
      for (int unsigned j = 0; j < i; j++) begin
        end_a[n_edges] = 12'(i);
        end_b[n_edges] = 12'(j);
        end_live[n_edges] = 1'b1;
        n_edges++;
      end
    end
    deg_sum = (m0 - 1) * m0;
    live_cnt = m0;
    grow_node = m0;
  endfunction

  // roulette walk over cumulative degree, then link the growing node
  function automatic void attach_draw(int unsigned r, ref graph_result_t res);
    int unsigned m, p, d;
    longint unsigned cum, goal;
    m = links_cfg;
    if (m == 0) m = 1;
    if (m > LINKS) m = LINKS;
    if (grow_node >= NODES) begin
      res.status = ST_FULL;
      return;
    end
    if (deg_sum == 0) begin
      res.status = ST_EMPTY;
      return;
    end
    goal = longint'(deg_sum) * r;
    cum = deg[0];
    p = 0;
    while ((cum << 16) < goal && p + 1 < NODES) begin
      p++;
      cum += deg[p];
    end
    res.node_id = 12'(p);
    if (p == grow_node) begin
      res.status = ST_REJECT;
      return;
    end
    d = deg[grow_node];
    if (d >= LINKS) begin
      res.status = ST_FULL;
      return;
    end
    for (int unsigned j = 0; j < d; j++)
      if (linked[j] == p) begin
        res.status = ST_REJECT;
        return;
      end
    if (n_edges >= EDGES) begin
      res.status = ST_FULL;
      return;
    end
    end_a[n_edges] = 12'(grow_node);
    end_b[n_edges] = 12'(p);
    end_live[n_edges] = 1'b1;
    n_edges++;
    linked[d] = p;
    add_degree(grow_node);
    add_degree(p);
    deg_sum += 2;
    if (deg[grow_node] >= m) begin
      res.node_complete = 1'b1;
      grow_node++;
    end
  endfunction

  function automatic void delete_draw(int unsigned r, ref graph_result_t res);
    int unsigned cand;
    cand = steps != 0 ? r % steps : r;
    res.node_id = 12'(cand);
    if (cand >= NODES || deg[cand] == 0) begin
      res.status = ST_DEAD;
      return;
    end
    for (int unsigned q = 0; q < n_edges; q++) begin
      if (!end_live[q]) continue;
      if (end_a[q] == cand) drop_degree(end_b[q]);
      else if (end_b[q] == cand) drop_degree(end_a[q]);
      else continue;
      end_live[q] = 1'b0;
      deg_sum = deg_sum >= 2 ? deg_sum - 2 : 0;
    end
    deg[cand] = 0;
    if (live_cnt > 0) live_cnt--;
  endfunction

  function automatic graph_result_t graph_predict(graph_item_t it);
    graph_result_t res;
    int unsigned r;
    r = it.rand_value;
    res = '{default: '0};
    res.status = ST_OK;
    case (it.op)
      OP_SEED: seed_graph(res);
      OP_STEP: begin
        if (live_cnt == 0) res.status = ST_EMPTY;
        else begin
          steps++;
          if (r >= thresh_cfg) begin
            res.chose_grow = 1'b1;
            res.node_id = 12'(grow_node);
            if (grow_node >= NODES) res.status = ST_FULL;
          end
        end
      end
      OP_ATTACH: attach_draw(r, res);
      OP_DELETE: delete_draw(r, res);
      OP_READ: begin
        if (it.edge_slot < n_edges) begin
          res.edge_end_a = end_a[it.edge_slot];
          res.edge_end_b = end_b[it.edge_slot];
          res.edge_alive = end_live[it.edge_slot];
        end
      end
      default: ;
    endcase
    res.live_nodes = 13'(live_cnt);
    res.degree_total = 16'(deg_sum);
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  task automatic check_result(graph_result_t got);
    graph_result_t want;
    if (expected_results.size() == 0) begin
      report_mismatch("unexpected result beat, status", got.status, 0);
      return;
    end
    want = expected_results.pop_front();
    if (got.status !== want.status) report_mismatch("status", got.status, want.status);
    if (got.chose_grow !== want.chose_grow)
      report_mismatch("chose_grow", got.chose_grow, want.chose_grow);
    if (got.node_id !== want.node_id) report_mismatch("node_id", got.node_id, want.node_id);
    if (got.node_complete !== want.node_complete)
      report_mismatch("node_complete", got.node_complete, want.node_complete);
    if (got.edge_end_a !== want.edge_end_a)
      report_mismatch("edge_end_a", got.edge_end_a, want.edge_end_a);
    if (got.edge_end_b !== want.edge_end_b)
      report_mismatch("edge_end_b", got.edge_end_b, want.edge_end_b);
    if (got.edge_alive !== want.edge_alive)
      report_mismatch("edge_alive", got.edge_alive, want.edge_alive);
    if (got.live_nodes !== want.live_nodes)
      report_mismatch("live_nodes", got.live_nodes, want.live_nodes);
    if (got.degree_total !== want.degree_total)
      report_mismatch("degree_total", got.degree_total, want.degree_total);
  endtask

  // driver
  always @(posedge clk) begin
    graph_item_t it;
    if (rst) begin
      item_if.valid <= 1'b0;
    end else if (!item_if.valid || item_if.ready) begin
      if (pending_items.size() > 0 && $urandom_range(99) >= idle_pct) begin
        it = pending_items.pop_front();
        item_if.valid <= 1'b1;
        item_if.op <= it.op;
        item_if.rand_value <= it.rand_value;
        item_if.edge_slot <= it.edge_slot;
      end else begin
        item_if.valid <= 1'b0;
      end
    end
  end

  // result sink, with a long hold-off whenever hold_req changes
  always @(posedge clk) begin
    if (rst) begin
      result_if.ready <= 1'b0;
      hold_left <= 0;
      hold_seen <= 0;
    end else if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      result_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      result_if.ready <= 1'b0;
    end else begin
      result_if.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // monitor, predictor and watchdog
  always @(posedge clk) begin
    graph_item_t   it;
    graph_result_t got;
    bit            moved;
    if (!rst) begin
      moved = 1'b0;
      if (cfg_if.valid && cfg_if.ready) begin
        moved = 1'b1;
        case (cfg_if.index)
          CFG_SEED_NODES:     seed_cfg = cfg_if.data[6:0];
          CFG_LINKS_PER_NODE: links_cfg = cfg_if.data[6:0];
          CFG_GROW_THRESHOLD: thresh_cfg = cfg_if.data;
          default: ;
        endcase
      end
      if (item_if.valid && item_if.ready) begin
        moved = 1'b1;
        it.op = item_if.op;
        it.rand_value = item_if.rand_value;
        it.edge_slot = item_if.edge_slot;
        expected_results.push_back(graph_predict(it));
      end
      if (result_if.valid && result_if.ready) begin
        moved = 1'b1;
        got.status = result_if.status;
        got.chose_grow = result_if.chose_grow;
        got.node_id = result_if.node_id;
        got.node_complete = result_if.node_complete;
        got.edge_end_a = result_if.edge_end_a;
        got.edge_end_b = result_if.edge_end_b;
        got.edge_alive = result_if.edge_alive;
        got.live_nodes = result_if.live_nodes;
        got.degree_total = result_if.degree_total;
        check_result(got);
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_CYCLES) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  task automatic add_item(logic [2:0] op, int unsigned r, int unsigned slot);
    graph_item_t it;
    it.op = op;
    it.rand_value = 16'(r);
    it.edge_slot = 14'(slot);
    pending_items.push_back(it);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [16:0] val);
    @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= val;
    forever begin
      @(negedge clk);
      if (cfg_if.ready) break;
    end
    @(posedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic drain;
    forever begin
      @(negedge clk);
      if (pending_items.size() == 0 && !item_if.valid && expected_results.size() == 0) break;
    end
    repeat (20) @(negedge clk);
  endtask

  // mostly grow-and-attach sequences with random draws, some seeds, deletes, reads and noise
  task automatic random_traffic(int n);
    int count, c, draws, eff;
    count = 0;
    while (count < n) begin
      c = $urandom_range(99);
      eff = links_cfg == 0 ? 1 : (links_cfg > LINKS ? LINKS : links_cfg);
      if (c < 6) begin
        add_item(OP_SEED, $urandom, $urandom);
        count++;
      end else if (c < 75) begin
        add_item(OP_STEP, $urandom_range(65535), $urandom);
        draws = $urandom_range(3) == 0 ? eff : $urandom_range(1, eff > 6 ? 6 : eff);
        repeat (draws) add_item(OP_ATTACH, $urandom_range(65535), $urandom);
        count += 1 + draws;
      end else if (c < 87) begin
        add_item(OP_DELETE, $urandom_range(1) ? $urandom_range(40) : $urandom_range(65535),
                 $urandom);
        count++;
      end else if (c < 97) begin
        add_item(OP_READ, $urandom,
                 $urandom_range(3) == 0 ? $urandom_range(16383) : $urandom_range(300));
        count++;
      end else begin
        add_item(3'(int'(OP_READ) + $urandom_range(1, 3)), $urandom, $urandom);
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    item_if.valid = 1'b0;
    item_if.op = OP_SEED;
    item_if.rand_value = '0;
    item_if.edge_slot = '0;
    result_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = CFG_SEED_NODES;
    cfg_if.data = '0;
    idle_pct = 0;
    stall_pct = 0;
    hold_req = 0;
    mismatches = 0;
    quiet_cycles = 0;
    foreach (deg[i]) deg[i] = 0;
    n_edges = 0;
    deg_sum = 0;
    grow_node = 0;
    steps = 0;
    live_cnt = 0;
    seed_cfg = 5;
    links_cfg = 4;
    thresh_cfg = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // empty graph, dead candidate, reads past the list, unused ops, then a seeded graph
    add_item(OP_ATTACH, 100, 0);
    add_item(OP_STEP, 0, 0);
    add_item(OP_DELETE, 0, 0);
    add_item(OP_READ, 0, 0);
    for (int k = 1; k <= 3; k++) add_item(3'(int'(OP_READ) + k), 16'hffff, 14'h3fff);
    add_item(OP_SEED, 0, 0);
    add_item(OP_STEP, 0, 0);
    add_item(OP_ATTACH, 0, 0);
    add_item(OP_ATTACH, 0, 0);
    add_item(OP_ATTACH, 65535, 0);
    add_item(OP_ATTACH, 32768, 0);
    add_item(OP_ATTACH, 20000, 0);
    add_item(OP_STEP, 65535, 0);
    add_item(OP_ATTACH, 65535, 0);
    add_item(OP_ATTACH, 65535, 0);
    add_item(OP_DELETE, 1, 0);
    add_item(OP_DELETE, 65535, 0);
    add_item(OP_READ, 0, 0);
    add_item(OP_READ, 9, 0);
    add_item(OP_READ, 0, 16383);
    add_item(OP_ATTACH, 40000, 0);
    drain();

    write_reg(CFG_SEED_NODES, 17'd2);
    write_reg(CFG_LINKS_PER_NODE, 17'd1);
    write_reg(CFG_GROW_THRESHOLD, 17'd65536);
    idle_pct = 80;
    add_item(OP_SEED, 0, 0);
    add_item(OP_STEP, 65535, 0);
    random_traffic(20);
    drain();

    write_reg(CFG_GROW_THRESHOLD, 17'd1);
    write_reg(CFG_SEED_NODES, 17'd64);
    write_reg(CFG_LINKS_PER_NODE, 17'd64);
    idle_pct = 0;
    stall_pct = 80;
    add_item(OP_SEED, 0, 0);
    add_item(OP_STEP, 0, 0);
    random_traffic(20);
    drain();

    write_reg(CFG_SEED_NODES, 17'd0);
    write_reg(CFG_LINKS_PER_NODE, 17'd0);
    write_reg(CFG_GROW_THRESHOLD, 17'd32768);
    idle_pct = 37;
    stall_pct = 37;
    add_item(OP_SEED, 0, 0);
    random_traffic(20);
    drain();

    write_reg(CFG_SEED_NODES, 17'd127);
    write_reg(CFG_LINKS_PER_NODE, 17'd127);
    write_reg(CFG_GROW_THRESHOLD, 17'd0);
    idle_pct = 0;
    stall_pct = 0;
    add_item(OP_SEED, 0, 0);
    random_traffic(20);
    @(negedge clk);
    hold_req = 1;
    drain();

    write_reg(CFG_SEED_NODES, 17'd7);
    write_reg(CFG_LINKS_PER_NODE, 17'd3);
    write_reg(CFG_GROW_THRESHOLD, 17'd16384);
    add_item(OP_SEED, 0, 0);
    random_traffic(18);
    drain();

    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+hdl
hdl/pag_pkg.sv
hdl/pag_in_if.sv
hdl/pag_out_if.sv
hdl/pag_cfg_if.sv
hdl/preferential_attachment_graph.sv
hdl/pag_checker.sv
tb/tb_top.sv
